// ===== rtl/rlp_enc_pkg.sv =====
// ============================================================================
// rlp_enc_pkg - shared types and constants of the RLP stream encoder
// Opcodes, header base values and the accepted-item record.
// ============================================================================
package rlp_enc_pkg;

    // input item kinds, carried on s_axis_tuser
    typedef enum logic {
        OP_ITEM = 1'b0,
        OP_LIST = 1'b1
    } t_op;

    // configuration register indexes
    localparam int unsigned REG_ZERO_AS_EMPTY = 0;
    localparam int unsigned REG_COUNT         = 1;

    // length field geometry
    localparam int unsigned LEN_W             = 32;
    localparam int unsigned LEN_W_BYTES       = LEN_W / 8;
    localparam int unsigned LEN_BYTES_MAX_DEF = 4;

    // RLP header bases and limits
    localparam logic [7:0]       C_STR_SHORT  = 8'h80;
    localparam logic [7:0]       C_STR_LONG   = 8'hB7;
    localparam logic [7:0]       C_LIST_SHORT = 8'hC0;
    localparam logic [7:0]       C_LIST_LONG  = 8'hF7;
    localparam logic [7:0]       C_SINGLE_LIM = 8'h80;   // 128
    localparam logic [LEN_W-1:0] C_SHORT_MAX  = 32'd55;

    // accepted input item
    typedef struct packed {
        t_op              op;
        logic [LEN_W-1:0] item_length;
        logic [7:0]       data_byte;
    } t_item;

    // length bytes actually usable: a 32-bit length never needs more than four
    function automatic int unsigned len_bytes_eff(input int unsigned lim);
        return (lim < LEN_W_BYTES) ? lim : LEN_W_BYTES;
    endfunction

endpackage

// ===== rtl/rlp_enc_frame.sv =====
// ============================================================================
// rlp_enc_frame - result list builder
// Turns one registered item and the open-item count into the list of
// encoded bytes it causes, their completion flags and the new count.
// ============================================================================
module rlp_enc_frame
    import rlp_enc_pkg::*;
#(
    parameter int unsigned LEN_BYTES_MAX = LEN_BYTES_MAX_DEF
) (
    input  t_item                    i_item,
    input  logic [LEN_W-1:0]         i_rem,
    input  logic                     i_zero_as_empty,
    output logic [len_bytes_eff(LEN_BYTES_MAX)+1:0][7:0] o_bytes,
    output logic [len_bytes_eff(LEN_BYTES_MAX)+1:0]      o_done,
    output logic [$clog2(len_bytes_eff(LEN_BYTES_MAX)+3)-1:0] o_cnt,
    output logic [LEN_W-1:0]         o_rem
);

    localparam int unsigned LB      = len_bytes_eff(LEN_BYTES_MAX);
    localparam int unsigned MAX_RES = LB + 2;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
    localparam int unsigned NB_W    = $clog2(LEN_W_BYTES + 1);
    localparam int unsigned IDX_W   = $clog2(LEN_W_BYTES);

    logic [NB_W-1:0]           nb;
    logic                      too_long;
    logic [LB-1:0][7:0]        len_be;    // length bytes, most significant first
    logic [NB_W-1:0]           sel_tmp;
    logic [LEN_W-1:0]          len;
    logic [LEN_W-1:0]          rem_dec;
    logic [7:0]                d;

    assign len     = i_item.item_length;
    assign d       = i_item.data_byte;
    assign rem_dec = i_rem - LEN_W'(1);

    // significant byte count of the length
    always_comb begin
        nb = '0;
        for (int j = 0; j < LEN_W_BYTES; j++) begin
            if (len[8*j +: 8] != 8'h00) begin
                nb = NB_W'(j + 1);
            end
        end
    end

    assign too_long = (nb > NB_W'(LB));

    // big-endian length bytes without leading zeros
    always_comb begin
        sel_tmp = '0;
        len_be  = '0;
        for (int i = 0; i < LB; i++) begin
            sel_tmp = nb - NB_W'(i + 1);
            if (NB_W'(i) < nb) begin
                len_be[i] = len[8*sel_tmp[IDX_W-1:0] +: 8];
            end
        end
    end

    always_comb begin
        o_bytes = '0;
        o_done  = '0;
        o_cnt   = '0;
        o_rem   = i_rem;
        priority if (i_item.op == OP_LIST) begin
            if (i_rem != '0) begin
                o_cnt = '0;                         // list inside open item: dropped
            end else if (len <= C_SHORT_MAX) begin
                o_bytes[0] = C_LIST_SHORT + len[7:0];
                o_done[0]  = 1'b1;
                o_cnt      = CNT_W'(1);
            end else if (!too_long) begin
                o_bytes[0] = C_LIST_LONG + 8'(nb);
                for (int i = 0; i < LB; i++) begin
                    o_bytes[i+1] = len_be[i];
                    o_done[i+1]  = (NB_W'(i + 1) == nb);
                end
                o_cnt = CNT_W'(nb) + CNT_W'(1);
            end
        end else if (i_rem != '0) begin
            o_bytes[0] = d;
            o_done[0]  = (rem_dec == '0);
            o_cnt      = CNT_W'(1);
            o_rem      = rem_dec;
        end else if (len == '0) begin
            o_bytes[0] = C_STR_SHORT;
            o_done[0]  = 1'b1;
            o_cnt      = CNT_W'(1);
        end else if ((len == LEN_W'(1)) && (d < C_SINGLE_LIM)) begin
            o_bytes[0] = ((d == 8'h00) && i_zero_as_empty) ? C_STR_SHORT : d;
            o_done[0]  = 1'b1;
            o_cnt      = CNT_W'(1);
        end else if (len <= C_SHORT_MAX) begin
            o_bytes[0] = C_STR_SHORT + len[7:0];
            o_bytes[1] = d;
            o_done[1]  = (len == LEN_W'(1));
            o_cnt      = CNT_W'(2);
            o_rem      = len - LEN_W'(1);
        end else if (!too_long) begin
            // long string header; payload byte follows the length bytes
            o_bytes[0] = C_STR_LONG + 8'(nb);
            for (int i = 0; i < LB; i++) begin
                if (NB_W'(i) < nb) begin
                    o_bytes[i+1] = len_be[i];
                end else if (NB_W'(i) == nb) begin
                    o_bytes[i+1] = d;
                end
            end
            if (nb == NB_W'(LB)) begin
                o_bytes[LB+1] = d;
            end
            o_cnt = CNT_W'(nb) + CNT_W'(2);
            o_rem = len - LEN_W'(1);
        end else begin
            o_cnt = '0;                             // length too wide: rejected
        end
    end

endmodule

// ===== rtl/rlp_stream_encoder.sv =====
// ============================================================================
// rlp_stream_encoder - streaming RLP encoder
// Wraps item payload bytes in RLP string headers and emits list headers.
// ============================================================================
//
//  channel   | dir | handshake          | contents
//  ----------+-----+--------------------+--------------------------------------
//  s_axis    | in  | tvalid/tready      | tdata: length, byte; tuser: op
//  m_axis    | out | tvalid/tready      | tdata: encoded byte; tlast; tuser
//  apb       | in  | psel/penable/pready| reg 0 at 0x0: zero_byte_as_empty
//
//  Flow: an item is held in the input register, then its result
//  bytes (up to LEN_BYTES+2) leave one per cycle from the result buffer
//  while m_axis_tready is high, so payload items stream at one item per
//  cycle unless stalled; a header item sends each header byte in turn.
//  Reset: synchronous, active low; no item open, mode register set to 1.
//  Stalls: input is taken while the result buffer drains its last byte,
//  so the two sides decouple by one item.
//
module rlp_stream_encoder
    import rlp_enc_pkg::*;
#(
    parameter int unsigned LEN_BYTES_MAX = LEN_BYTES_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] item_length, [39:32] data_byte
    input  logic        s_axis_tuser,   // [0] op
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] item_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned LB      = (LEN_BYTES_MAX < LEN_W_BYTES) ? LEN_BYTES_MAX
                                                                     : LEN_W_BYTES;
    localparam int unsigned MAX_RES = LB + 2;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    // configuration
    logic                 r_zero_as_empty;
    logic                 reg_hit;

    // input register
    logic                 r_a_vld;
    t_item                r_a;

    // open-item count
    logic [LEN_W-1:0]     r_rem;

    // result buffer, entry 0 is presented
    logic [MAX_RES-1:0][7:0] r_b_byte;
    logic [MAX_RES-1:0]      r_b_done;
    logic [CNT_W-1:0]        r_b_cnt;

    // builder outputs
    logic [MAX_RES-1:0][7:0] f_bytes;
    logic [MAX_RES-1:0]      f_done;
    logic [CNT_W-1:0]        f_cnt;
    logic [LEN_W-1:0]        n_rem;

    logic                 s_acc;
    logic                 b_take;
    logic                 b_free;
    logic                 a_move;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'(REG_ZERO_AS_EMPTY));
    assign prdata  = reg_hit ? {31'd0, r_zero_as_empty} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_as_empty <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_zero_as_empty <= pwdata[0];
        end
    end

    // ---------------------------------------------------------- handshake
    // buffer frees when empty or when its last byte leaves this cycle
    assign b_take        = (r_b_cnt != '0) && m_axis_tready;
    assign b_free        = (r_b_cnt == '0) || ((r_b_cnt == CNT_W'(1)) && m_axis_tready);
    assign a_move        = r_a_vld && b_free;
    assign s_axis_tready = !r_a_vld || a_move;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_acc) begin
            r_a_vld <= 1'b1;
        end else if (a_move) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a.op          <= t_op'(s_axis_tuser);
            r_a.item_length <= s_axis_tdata[31:0];
            r_a.data_byte   <= s_axis_tdata[39:32];
        end
    end

    // ------------------------------------------------------------ builder
    rlp_enc_frame #(
        .LEN_BYTES_MAX (LEN_BYTES_MAX)
    ) u_frame (
        .i_item          (r_a),
        .i_rem           (r_rem),
        .i_zero_as_empty (r_zero_as_empty),
        .o_bytes         (f_bytes),
        .o_done          (f_done),
        .o_cnt           (f_cnt),
        .o_rem           (n_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (a_move) begin
            r_rem <= n_rem;
        end
    end

    // ------------------------------------------------------ result buffer
    // rejected items load a zero count and simply vanish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_cnt <= '0;
        end else if (a_move) begin
            r_b_cnt <= f_cnt;
        end else if (b_take) begin
            r_b_cnt <= r_b_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_byte <= f_bytes;
            r_b_done <= f_done;
        end else if (b_take) begin
            r_b_byte <= r_b_byte >> 8;
            r_b_done <= r_b_done >> 1;
        end
    end

    assign m_axis_tvalid = (r_b_cnt != '0);
    assign m_axis_tdata  = r_b_byte[0];
    assign m_axis_tlast  = (r_b_cnt == CNT_W'(1));
    assign m_axis_tuser  = r_b_done[0];

    // --------------------------------------------------------- assertions
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_cnt <= CNT_W'(MAX_RES))
        else $error("result count beyond buffer depth");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_a_vld && !b_free))
        else $error("input stalled with room available");

    a_payload_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && (r_a.op == OP_ITEM) && (r_rem != '0))
        |=> (r_rem == $past(r_rem) - LEN_W'(1)))
        else $error("open item count did not step down");

    a_list_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && (r_a.op == OP_LIST)) |=> $stable(r_rem))
        else $error("list header changed open item count");

endmodule

// ===== tb/sv/rlp_stream_encoder_tb.sv =====
// ============================================================================
// rlp_stream_encoder_tb - self-checking bench for the RLP stream encoder
// Drives string items, payload bytes and list header requests into the
// stream input, predicts every encoded byte with a local RLP model and checks
// each output item field by field. Runs through both zero-byte modes and
// several sender/receiver idling patterns.
// ============================================================================
module rlp_stream_encoder_tb;
    import rlp_enc_pkg::*;

    localparam int unsigned WDOG_LIMIT    = 4000;  // cycles with no handshake at all
    localparam int unsigned SETTLE_CYCLES = 12;    // input reg + longest header + margin
    localparam int unsigned LEN_BYTES_MAX = LEN_BYTES_MAX_DEF;
    localparam logic [2:0]  ADDR_ZERO_AS_EMPTY = 3'(4 * REG_ZERO_AS_EMPTY);

    // one encoded output item as predicted
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       done;
    } t_enc_byte;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [31:0] item_length, [39:32] data_byte
    logic        s_axis_tuser;   // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;   // run_last
    logic        m_axis_tuser;   // [0] item_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rlp_stream_encoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_enc_byte   enc_q[$];        // encoded bytes still to come, oldest first
    logic [31:0] open_bytes;      // payload bytes still owed by the open string
    logic        zero_as_empty;   // local copy of the mode register
    int unsigned fails;
    int unsigned items_sent;      // items that produced output (ignored ones excluded)
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // RLP predictor
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] v, input logic done);
        t_enc_byte e;
        e.value = v;
        e.last  = 1'b0;
        e.done  = done;
        enc_q.insert(enc_q.size(), e);
    endfunction

    // minimal number of bytes to hold len (no leading zeros)
    function automatic int unsigned len_bytes(input logic [31:0] len);
        int unsigned n;
        n = 0;
        while (len != '0) begin
            len = len >> 8;
            n++;
        end
        return n;
    endfunction

    // base+n, then the length big-endian
    function automatic void push_long_header(input logic [7:0] base, input logic [31:0] len,
                                             input int unsigned n, input logic done_at_end);
        push_byte(base + 8'(n), 1'b0);
        for (int i = int'(n) - 1; i >= 0; i--) begin
            push_byte(len[8*i +: 8], (i == 0) ? done_at_end : 1'b0);
        end
    endfunction

    // queues the bytes caused by one accepted item; returns how many
    function automatic int unsigned encode_item(input t_op op, input logic [31:0] len,
                                                input logic [7:0] d);
        int unsigned n0;
        int unsigned nlen;
        n0   = enc_q.size();
        nlen = len_bytes(len);
        if (op == OP_LIST) begin
            // list request inside an open string is dropped
            if (open_bytes == '0) begin
                if (len <= C_SHORT_MAX) begin
                    push_byte(C_LIST_SHORT + len[7:0], 1'b1);
                end else if (nlen <= LEN_BYTES_MAX) begin
                    push_long_header(C_LIST_LONG, len, nlen, 1'b1);
                end
            end
        end else if (open_bytes != '0) begin
            open_bytes = open_bytes - 1;
            push_byte(d, open_bytes == '0);
        end else if (len == '0) begin
            push_byte(C_STR_SHORT, 1'b1);
        end else if (len == 32'd1 && d < C_SINGLE_LIM) begin
            push_byte((d == 8'h00 && zero_as_empty) ? C_STR_SHORT : d, 1'b1);
        end else if (len <= C_SHORT_MAX || nlen <= LEN_BYTES_MAX) begin
            if (len <= C_SHORT_MAX) begin
                push_byte(C_STR_SHORT + len[7:0], 1'b0);
            end else begin
                push_long_header(C_STR_LONG, len, nlen, 1'b0);
            end
            open_bytes = len - 1;
            push_byte(d, open_bytes == '0);
        end
        if (enc_q.size() > n0) begin
            enc_q[enc_q.size() - 1].last = 1'b1;
        end
        return enc_q.size() - n0;
    endfunction

    // ------------------------------------------------------------------------
    // Output check: every accepted output item against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_enc_byte e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (enc_q.size() == 0) begin
                $error("unexpected output item: out_byte %h", m_axis_tdata);
                fails++;
            end else begin
                e = enc_q.pop_front();
                if (m_axis_tdata !== e.value) begin
                    $error("out_byte: expected %h, got %h", e.value, m_axis_tdata);
                    fails++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("run_last: expected %b, got %b", e.last, m_axis_tlast);
                    fails++;
                end
                if (m_axis_tuser !== e.done) begin
                    $error("item_done: expected %b, got %b", e.done, m_axis_tuser);
                    fails++;
                end
            end
        end
    end

    // watchdog: no handshake on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All tasks are entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Presents one item, waits for it to be taken, then predicts its output.
    // tvalid is left high; the next call may lower it, drain_results does.
    task automatic send_item(input t_op op, input logic [31:0] len, input logic [7:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, len};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (encode_item(op, len, d) != 0) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    // Stops sending, lets every predicted byte arrive, then lets the
    // pipeline settle (a dropped list request leaves nothing to wait on).
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (enc_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_ZERO_AS_EMPTY) begin
            zero_as_empty = data[0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata: expected %h, got %h", want, prdata);
            fails++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mode(input logic mode);
        apb_write(ADDR_ZERO_AS_EMPTY, {31'b0, mode});
        apb_read_check(ADDR_ZERO_AS_EMPTY, {31'b0, mode});
    endtask

    // ------------------------------------------------------------------------
    // Random content helpers
    // ------------------------------------------------------------------------
    // zero is weighted up: it is the special single byte
    function automatic logic [7:0] pick_data();
        return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
    endfunction

    // mostly short strings so the run stays near its item budget
    function automatic logic [31:0] pick_string_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 32'd0;
        if (r < 35) return 32'd1;
        if (r < 80) return $urandom_range(8, 2);
        if (r < 92) return $urandom_range(55, 9);
        return $urandom_range(72, 56);
    endfunction

    // one length class per header form, up to the full 32 bits
    function automatic logic [31:0] pick_list_len();
        case ($urandom_range(4))
            0:       return $urandom_range(55, 0);
            1:       return $urandom_range(255, 56);
            2:       return $urandom_range(32'h0000_FFFF, 32'h0000_0100);
            3:       return $urandom_range(32'h00FF_FFFF, 32'h0001_0000);
            default: return $urandom;
        endcase
    endfunction

    // one whole string: opening item then its payload bytes; the length
    // field of payload items is junk, and now and then a list request is
    // slipped in that must be dropped
    task automatic send_string(input logic [31:0] len);
        send_item(OP_ITEM, len, pick_data());
        for (int unsigned i = 1; i < len; i++) begin
            if ($urandom_range(99) < 5) begin
                send_item(OP_LIST, $urandom, 8'($urandom_range(255)));
            end
            send_item(OP_ITEM, $urandom, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // short and single-byte strings, every list header form, dropped list
    task automatic test_directed_items();
        apb_read_check(ADDR_ZERO_AS_EMPTY, 32'd1);   // mode resets to 1
        send_item(OP_ITEM, 32'd0, 8'hA5);            // empty string
        send_item(OP_ITEM, 32'd1, 8'h00);            // zero byte, mode set
        send_item(OP_ITEM, 32'd1, 8'h7F);            // top of single-byte range
        send_item(OP_ITEM, 32'd1, 8'h80);            // needs a header
        send_item(OP_ITEM, 32'd1, 8'hFF);
        send_item(OP_ITEM, 32'd2, 8'hAA);
        send_item(OP_ITEM, 32'hFFFF_FFFF, 8'h55);    // payload: length ignored
        // list request while a string is open is dropped
        send_item(OP_ITEM, 32'd3, 8'h00);
        send_item(OP_LIST, 32'd7, 8'h00);
        send_item(OP_ITEM, 32'd0, 8'h01);
        send_item(OP_ITEM, 32'd0, 8'hFE);
        // list headers at each short/long boundary
        send_item(OP_LIST, 32'd0, 8'h00);
        send_item(OP_LIST, 32'd55, 8'hFF);
        send_item(OP_LIST, 32'd56, 8'h00);
        send_item(OP_LIST, 32'h0000_00FF, 8'h00);
        send_item(OP_LIST, 32'h0000_0100, 8'h00);
        send_item(OP_LIST, 32'h0000_FFFF, 8'h00);
        send_item(OP_LIST, 32'h0001_0000, 8'h00);
        send_item(OP_LIST, 32'h00FF_FFFF, 8'h00);
        send_item(OP_LIST, 32'h0100_0000, 8'h00);
        send_item(OP_LIST, 32'hFFFF_FFFF, 8'h00);
        drain_results();
    endtask

    // zero byte with the mode cleared and set again
    task automatic test_zero_byte_mode();
        set_mode(1'b0);
        send_item(OP_ITEM, 32'd1, 8'h00);
        send_item(OP_ITEM, 32'd1, 8'h01);
        drain_results();
        set_mode(1'b1);
        send_item(OP_ITEM, 32'd1, 8'h00);
        drain_results();
    endtask

    // one idling pattern with random strings and list headers
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input logic mode, input logic [31:0] first_len,
                             input int unsigned n_items);
        int unsigned start;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        set_mode(mode);
        start = items_sent;
        send_string(first_len);
        drain_results();          // sender holds off until all output is out
        while (items_sent - start < n_items) begin
            if ($urandom_range(99) < 20) begin
                send_item(OP_LIST, pick_list_len(), 8'($urandom_range(255)));
            end else begin
                send_string(pick_string_len());
            end
            if ($urandom_range(99) < 4) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    task automatic test_random_streams();
        run_phase(0, 0, 1'b0, 32'd55, 80);
        run_phase(58, 0, 1'b1, 32'd56, 80);
        run_phase(0, 58, 1'b0, 32'd1, 80);
        run_phase(27, 27, 1'b1, 32'd0, 80);
    endtask

    // widest string header; the string can never close, so this goes last
    task automatic test_open_long_item();
        send_item(OP_ITEM, 32'hFFFF_FFFF, 8'h80);
        send_item(OP_ITEM, $urandom, 8'h00);
        send_item(OP_LIST, 32'd3, 8'h00);
        send_item(OP_ITEM, $urandom, 8'hFF);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        open_bytes     = '0;
        zero_as_empty  = 1'b1;
        fails          = 0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        idle_cycles    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_items();
        test_zero_byte_mode();
        test_random_streams();
        test_open_long_item();

        if (fails == 0 && enc_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
